/* sv/pie_pkg.sv */
package pie_pkg;

  localparam int MaxNodes = 16;
  localparam int IdxW = $clog2(MaxNodes);
  localparam int CntW = 5;
  localparam int DataW = 32;
  localparam int FracBits = 16;
  localparam int ProdW = 64;
  localparam int NumW = 65;
  localparam int DenW = 33;
  localparam int QuoW = NumW;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CMP,
    S_INIT,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_SUM,
    S_UPD_DIV,
    S_UPD_WR,
    S_FIN_RD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic         load;
    logic         init_copy;
    logic         rd_pair;
    logic         cmp_dup;
    logic         mul;
    logic         sum;
    logic         div_start;
    logic         wr_p;
    logic         clr_sat;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic dup;
    logic div_done;
  } sts_t;

endpackage

/* sv/pie_div.sv */
module pie_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pie_pkg::NumW-1:0]  num,
  input  logic [pie_pkg::DenW-1:0]  den,
  output logic                      done,
  output logic [pie_pkg::QuoW-1:0]  quo,
  output logic [pie_pkg::DenW:0]    rem
);

  localparam int CW = $clog2(pie_pkg::NumW + 1);
  localparam int RW = pie_pkg::DenW + 1;

  logic [pie_pkg::QuoW-1:0] q_r, q_nxt;
  logic [pie_pkg::DenW:0]   r_r, r_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [pie_pkg::DenW+1:0] trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = '0;
    if (start) begin
      q_nxt = num;
      r_nxt = '0;
      cnt_nxt = CW'(pie_pkg::NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {r_r, q_r[pie_pkg::QuoW-1]};
      q_nxt = {q_r[pie_pkg::QuoW-2:0], 1'b0};
      if (trial >= {2'b00, den}) begin
        r_nxt = RW'(trial - {2'b00, den});
        q_nxt[0] = 1'b1;
      end else begin
        r_nxt = trial[pie_pkg::DenW:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo = q_r;
  assign rem = r_r;

endmodule

/* sv/pie_dp.sv */
module pie_dp (
  input  logic                         clk,
  input  pie_pkg::cmd_t                cmd,
  input  logic [pie_pkg::IdxW-1:0]     ld_index,
  input  logic signed [pie_pkg::DataW-1:0] ld_x,
  input  logic signed [pie_pkg::DataW-1:0] ld_y,
  input  logic signed [pie_pkg::DataW-1:0] xq,
  output pie_pkg::sts_t                sts,
  output logic signed [pie_pkg::DataW-1:0] res_y,
  output logic                         sat
);

  localparam int W = pie_pkg::DataW;

  logic signed [W-1:0] xmem [pie_pkg::MaxNodes];
  logic signed [W-1:0] ymem [pie_pkg::MaxNodes];
  logic signed [W-1:0] pmem [pie_pkg::MaxNodes];

  logic signed [W-1:0] xj_r, xk_r, pj_r, pk_r, yk_r;
  logic [pie_pkg::DenW-1:0] mdj_r, mdk_r, md_r;
  logic [W-1:0] mpj_r, mpk_r;
  logic sa_r, sb_r, sd_r;
  logic [pie_pkg::ProdW-1:0] pa_r, pb_r;
  logic na_r, nb_r;
  logic [pie_pkg::NumW-1:0] m_r;
  logic neg_r;
  logic sat_r;
  logic signed [W-1:0] wr_val;
  logic wr_sat;

  logic signed [pie_pkg::DenW-1:0] dj, dk, dd;
  logic div_done;
  logic [pie_pkg::QuoW-1:0] quo;
  logic [pie_pkg::DenW:0] rem;

  function automatic logic [pie_pkg::DenW-1:0] mag33(input logic signed [pie_pkg::DenW-1:0] v);
    mag33 = v[pie_pkg::DenW-1] ? pie_pkg::DenW'(-v) : v;
  endfunction

  function automatic logic [W-1:0] mag32(input logic signed [W-1:0] v);
    mag32 = v[W-1] ? W'(-v) : v;
  endfunction

  // Node memories: one write port, registered reads. The initial copy writes
  // the partial value of the row read on the previous cycle (index on j).
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xmem[ld_index] <= ld_x;
      ymem[ld_index] <= ld_y;
    end
    if (cmd.rd_pair) begin
      xj_r <= xmem[cmd.j];
      xk_r <= xmem[cmd.k];
      pj_r <= pmem[cmd.j];
      pk_r <= pmem[cmd.k];
      yk_r <= ymem[cmd.k];
    end
    if (cmd.init_copy) begin
      pmem[cmd.j] <= yk_r;
    end else if (cmd.wr_p) begin
      pmem[cmd.k] <= wr_val;
    end
  end

  assign dj = {xq[W-1], xq} - {xj_r[W-1], xj_r};
  assign dk = {xq[W-1], xq} - {xk_r[W-1], xk_r};
  assign dd = {xk_r[W-1], xk_r} - {xj_r[W-1], xj_r};
  assign sts.dup = (xj_r == xk_r);

  // First stage: magnitudes and signs.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mdj_r <= mag33(dj);
      mdk_r <= mag33(dk);
      md_r <= mag33(dd);
      mpk_r <= mag32(pk_r);
      mpj_r <= mag32(pj_r);
      sa_r <= pk_r[W-1] ^ dj[pie_pkg::DenW-1];
      sb_r <= pj_r[W-1] ^ dk[pie_pkg::DenW-1];
      sd_r <= dd[pie_pkg::DenW-1];
    end
  end

  // Second stage: two 32x33 products, then the signed sum of terms.
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      pa_r <= pie_pkg::ProdW'({33'd0, mpk_r} * {32'd0, mdj_r});
      pb_r <= pie_pkg::ProdW'({33'd0, mpj_r} * {32'd0, mdk_r});
      na_r <= sa_r;
      nb_r <= ~sb_r;
    end
  end

  logic na_e, nb_e;
  always_comb begin
    na_e = na_r && (pa_r != '0);
    nb_e = nb_r && (pb_r != '0);
  end

  // The products are registered on the sum command and the numerator is formed
  // from them in the following cycle; a second delay register starts the divider.
  logic div_go_r, div_go2_r;
  always_ff @(posedge clk) begin
    div_go_r <= cmd.div_start;
    div_go2_r <= div_go_r;
  end

  always_ff @(posedge clk) begin
    if (div_go_r) begin
      if (na_e == nb_e) begin
        m_r <= {1'b0, pa_r} + {1'b0, pb_r};
        neg_r <= na_e;
      end else if (pa_r >= pb_r) begin
        m_r <= {1'b0, pa_r - pb_r};
        neg_r <= na_e;
      end else begin
        m_r <= {1'b0, pb_r - pa_r};
        neg_r <= nb_e;
      end
    end
  end

  pie_div u_div (
    .clk  (clk),
    .rst_n(1'b1),
    .start(div_go2_r),
    .num  (m_r),
    .den  (md_r),
    .done (div_done),
    .quo  (quo),
    .rem  (rem)
  );
  assign sts.div_done = div_done;

  // Rounding, sign and saturation of the quotient.
  logic [pie_pkg::QuoW-1:0] qr;
  logic [pie_pkg::DenW:0] rcomp;
  logic neg_f;
  logic [W:0] lim;
  always_comb begin
    rcomp = {1'b0, md_r} - rem;
    if (quo > pie_pkg::QuoW'(33'h0FFFFFFFF)) begin
      qr = pie_pkg::QuoW'(33'h100000000);
    end else if (rem >= rcomp) begin
      qr = quo + 1'b1;
    end else begin
      qr = quo;
    end
    neg_f = (neg_r != sd_r) && (qr != '0);
    lim = neg_f ? 33'h080000000 : 33'h07FFFFFFF;
    wr_sat = 1'b0;
    if (qr > pie_pkg::QuoW'(lim)) begin
      qr = pie_pkg::QuoW'(lim);
      wr_sat = 1'b1;
    end
    wr_val = neg_f ? W'(-qr[W-1:0]) : qr[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_sat) begin
      sat_r <= 1'b0;
    end else if (cmd.wr_p && wr_sat) begin
      sat_r <= 1'b1;
    end
  end

  assign res_y = pk_r;
  assign sat = sat_r;

endmodule

/* sv/pie_ctrl.sv */
module pie_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic                        in_op,
  input  logic [pie_pkg::CntW-1:0]    node_count,
  input  pie_pkg::sts_t               sts,
  input  logic                        out_free,
  output pie_pkg::cmd_t               cmd,
  output logic                        busy,
  output logic                        res_valid,
  output logic                        res_dup
);

  localparam int IW = pie_pkg::IdxW;
  localparam int CW = pie_pkg::CntW;

  pie_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] j_r, j_nxt, k_r, k_nxt, n_r, n_nxt;
  logic dup_r, dup_nxt;
  logic [CW-1:0] nc;

  always_comb begin
    if (node_count == '0) nc = CW'(1);
    else if (node_count > CW'(pie_pkg::MaxNodes)) nc = CW'(pie_pkg::MaxNodes);
    else nc = node_count;
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    k_nxt = k_r;
    n_nxt = n_r;
    dup_nxt = dup_r;
    unique case (state_r)
      pie_pkg::S_IDLE: begin
        if (in_fire && in_op == pie_pkg::OP_EVAL) begin
          n_nxt = nc;
          j_nxt = '0;
          k_nxt = (nc == CW'(1)) ? CW'(0) : CW'(1);
          dup_nxt = 1'b0;
          state_nxt = (nc == CW'(1)) ? pie_pkg::S_INIT : pie_pkg::S_DUP_RD;
        end
      end
      pie_pkg::S_DUP_RD: state_nxt = pie_pkg::S_DUP_CMP;
      pie_pkg::S_DUP_CMP: begin
        if (sts.dup) begin
          dup_nxt = 1'b1;
          state_nxt = pie_pkg::S_OUT;
        end else if (k_r + 1'b1 < n_r) begin
          k_nxt = k_r + 1'b1;
          state_nxt = pie_pkg::S_DUP_RD;
        end else if (j_r + CW'(2) < n_r) begin
          j_nxt = j_r + 1'b1;
          k_nxt = j_r + CW'(2);
          state_nxt = pie_pkg::S_DUP_RD;
        end else begin
          k_nxt = '0;
          state_nxt = pie_pkg::S_INIT;
        end
      end
      pie_pkg::S_INIT: begin
        // Read row k then copy y into the partial value on the next pass.
        // With a single node there is nothing to update.
        if (k_r == n_r) begin
          j_nxt = '0;
          k_nxt = CW'(1);
          state_nxt = (n_r == CW'(1)) ? pie_pkg::S_FIN_RD : pie_pkg::S_UPD_RD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      pie_pkg::S_UPD_RD: state_nxt = pie_pkg::S_UPD_MUL;
      pie_pkg::S_UPD_MUL: state_nxt = pie_pkg::S_UPD_SUM;
      pie_pkg::S_UPD_SUM: state_nxt = pie_pkg::S_UPD_DIV;
      pie_pkg::S_UPD_DIV: if (sts.div_done) state_nxt = pie_pkg::S_UPD_WR;
      pie_pkg::S_UPD_WR: begin
        if (k_r + 1'b1 < n_r) begin
          k_nxt = k_r + 1'b1;
          state_nxt = pie_pkg::S_UPD_RD;
        end else if (j_r + CW'(2) < n_r) begin
          j_nxt = j_r + 1'b1;
          k_nxt = j_r + CW'(2);
          state_nxt = pie_pkg::S_UPD_RD;
        end else begin
          state_nxt = pie_pkg::S_FIN_RD;
        end
      end
      pie_pkg::S_FIN_RD: begin
        k_nxt = n_r - 1'b1;
        state_nxt = pie_pkg::S_OUT;
      end
      pie_pkg::S_OUT: if (out_free) state_nxt = pie_pkg::S_IDLE;
      default: state_nxt = pie_pkg::S_IDLE;
    endcase
  end

  // Commands. In S_INIT the first cycle only reads row k; later cycles write
  // row k-1, whose index travels on j, and also read row k while k is below n.
  always_comb begin
    cmd = '0;
    cmd.j = j_r[IW-1:0];
    cmd.k = k_r[IW-1:0];
    res_valid = 1'b0;
    unique case (state_r)
      pie_pkg::S_IDLE: begin
        cmd.load = in_fire && in_op == pie_pkg::OP_LOAD;
        cmd.clr_sat = 1'b1;
      end
      pie_pkg::S_DUP_RD: cmd.rd_pair = 1'b1;
      pie_pkg::S_DUP_CMP: ;
      pie_pkg::S_INIT: begin
        cmd.rd_pair = (k_r != n_r);
        if (k_r != '0) begin
          cmd.init_copy = 1'b1;
          cmd.j = IW'(k_r - 1'b1);
        end
      end
      pie_pkg::S_UPD_RD: cmd.rd_pair = 1'b1;
      pie_pkg::S_UPD_MUL: cmd.mul = 1'b1;
      pie_pkg::S_UPD_SUM: begin
        cmd.sum = 1'b1;
        cmd.div_start = 1'b1;
      end
      pie_pkg::S_UPD_DIV: ;
      pie_pkg::S_UPD_WR: cmd.wr_p = 1'b1;
      pie_pkg::S_FIN_RD: begin
        cmd.rd_pair = 1'b1;
        cmd.k = IW'(n_r - 1'b1);
      end
      pie_pkg::S_OUT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    k_r <= k_nxt;
    n_r <= n_nxt;
    dup_r <= dup_nxt;
    if (!rst_n) state_r <= pie_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != pie_pkg::S_IDLE);
  assign res_dup = dup_r;

endmodule

/* sv/polynomial_interpolation_eval.sv */
// Aitken-scheme polynomial interpolator in signed Q16.16. A word with
// operation 0 stores one node (x, y) into slot node_index and gives no result;
// a word with operation 1 evaluates the polynomial through the first
// node_count nodes at x_value and returns one result word. Nodes are first
// checked pairwise for equal abscissas (status 1, value 0); then the
// ordinates are copied into the working values. Every Aitken update runs
// through a two-multiplier stage and a shared restoring divider that retires
// one quotient bit per cycle. The block takes no new word until a query's
// result is handed to the output register, and that waits while the output
// stays stalled. A load is stored in the cycle in which it is accepted.
// Each update's quotient is rounded to nearest (ties away from zero) and
// clamped, and any clamp in a query gives status 2. Evaluating with a slot
// that was never loaded gives an undefined value. node_count is written on
// the cfg channel; the user must do so only while idle, as the block itself
// does not enforce it.
module polynomial_interpolation_eval (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // node_index[3:0], x_value[35:4], y_value[67:36], zero fill
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // interpolated_y
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // node_count
);

  pie_pkg::cmd_t cmd;
  pie_pkg::sts_t sts;
  logic [pie_pkg::CntW-1:0] node_count_r;
  logic busy, res_valid, res_dup, sat, in_fire;
  logic signed [31:0] res_y;
  logic out_free;
  logic signed [31:0] xq_r;

  logic        ov_r;
  logic [31:0] od_r;
  logic [1:0]  os_r;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free = !ov_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= 5'd1;
    else if (cfg_valid) node_count_r <= cfg_data;
  end

  pie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_op     (in_tuser),
    .node_count(node_count_r),
    .sts       (sts),
    .out_free  (out_free),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (res_valid),
    .res_dup   (res_dup)
  );

  pie_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .ld_index(in_tdata[3:0]),
    .ld_x    (in_tdata[35:4]),
    .ld_y    (in_tdata[67:36]),
    .xq      (xq_r),
    .sts     (sts),
    .res_y   (res_y),
    .sat     (sat)
  );

  always_ff @(posedge clk) begin
    if (in_fire) xq_r <= in_tdata[35:4];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res_valid && out_free) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (res_valid && out_free) begin
      od_r <= res_dup ? 32'd0 : res_y;
      os_r <= res_dup ? pie_pkg::ST_DUP : (sat ? pie_pkg::ST_SAT : pie_pkg::ST_OK);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = os_r;

endmodule
